>>> hdl/rhq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rhq_pkg
// Shared types and constants of the rgb to hsv palette quantizer.
// ---------------------------------------------------------------------------
package rhq_pkg;

   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam logic [4:0]  INDEX_BITS_RESET      = 5'd8;
   localparam logic [7:0]  HUE_BANDS_RESET       = 8'd6;
   localparam logic [7:0]  SHADES_RESET          = 8'd8;
   localparam logic [15:0] GREY_THRESHOLD_RESET  = 16'd6554;

   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      CSR_INDEX_BITS,
      CSR_HUE_BANDS,
      CSR_SHADES,
      CSR_GREY_THRESHOLD
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [15:0] palette_index;
      logic        is_grey;
   } rsp_type;

   // per item flags next to the hsv dividers
   typedef struct packed {
      logic bright;
      logic mx_zero;
      logic d_zero;
   } hsv_flags_type;

   // per item flags next to the shade divider
   typedef struct packed {
      logic grey;
      logic bright;
      logic e_zero;
   } shade_flags_type;

endpackage : rhq_pkg
`default_nettype wire

>>> hdl/rhq_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rhq_div
// Pipelined restoring divider: one quotient bit per stage, several lanes
// sharing one valid bit and one sideband word.
// ---------------------------------------------------------------------------
module rhq_div #(
   parameter int LANES  = 1,
   parameter int NUM_W  = 8,
   parameter int DEN_W  = 8,
   parameter int SIDE_W = 1
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic                             in_valid,
   input  wire logic [LANES-1:0][NUM_W-1:0]      num,
   input  wire logic [LANES-1:0][DEN_W-1:0]      den,
   input  wire logic [SIDE_W-1:0]                side,
   output logic                                  out_valid,
   output logic [LANES-1:0][NUM_W-1:0]           quo,
   output logic [SIDE_W-1:0]                     side_out
);

   logic [NUM_W-1:0]                   valid_ff;
   logic [LANES-1:0][NUM_W-1:0]        work_ff [NUM_W];
   logic [LANES-1:0][DEN_W-1:0]        rem_ff  [NUM_W];
   logic [LANES-1:0][DEN_W-1:0]        den_ff  [NUM_W];
   logic [SIDE_W-1:0]                  side_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic                          valid_src;
      logic [LANES-1:0][NUM_W-1:0]   work_src;
      logic [LANES-1:0][DEN_W-1:0]   rem_src;
      logic [LANES-1:0][DEN_W-1:0]   den_src;
      logic [SIDE_W-1:0]             side_src;
      logic [LANES-1:0][NUM_W-1:0]   work_in;
      logic [LANES-1:0][DEN_W-1:0]   rem_in;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign work_src  = num;
         assign rem_src   = '0;
         assign den_src   = den;
         assign side_src  = side;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign work_src  = work_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign den_src   = den_ff[k-1];
         assign side_src  = side_ff[k-1];
      end

      always_comb begin
         logic [DEN_W:0] trial;
         logic [DEN_W:0] diff;
         logic           ge;
         for (int l = 0; l < LANES; l++) begin
            trial      = {rem_src[l], work_src[l][NUM_W-1]};
            diff       = trial - {1'b0, den_src[l]};
            ge         = (trial >= {1'b0, den_src[l]});
            rem_in[l]  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            work_in[l] = {work_src[l][NUM_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            work_ff[k] <= work_in;
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign quo       = work_ff[NUM_W-1];
   assign side_out  = side_ff[NUM_W-1];

endmodule : rhq_div
`default_nettype wire

>>> hdl/rgb_to_hsv_palette_quantizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rgb_to_hsv_palette_quantizer_top
// Converts an rgb pixel to hsv fractions and maps it to a palette index.
// ---------------------------------------------------------------------------
// Takes one pixel per clock while not stalled and returns one result per
// pixel in order. The pipeline is built from two bit-serial divider
// pipelines: the hsv dividers (16 + FRACTION_BITS stages, two lanes for
// saturation and hue) and the shade divider (2*FRACTION_BITS + 9 stages),
// plus four plain register stages. When rsp_stall holds a waiting result
// the whole pipeline freezes and req_stall rises; nothing is dropped.
// Write the csr registers only while no item is in flight.
module rgb_to_hsv_palette_quantizer_top import rhq_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_payload,
   input  wire logic                  csr_we,
   input  wire csr_index_type         csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int F     = FRACTION_BITS;
   localparam int ONE_W = F + 1;
   localparam int NW1   = 16 + F;
   localparam int SW    = F + 17;
   localparam int TW    = F + 9;
   localparam int NW2   = 2 * F + 9;
   localparam int DW2   = F + 2;
   localparam int IW    = 2 * F + 10;
   localparam int SIDE1 = $bits(hsv_flags_type) + 8;
   localparam int SIDE2 = 3 + 2 * SW;
   localparam logic [ONE_W-1:0] ONE = {1'b1, {F{1'b0}}};

   // configuration
   logic [4:0]  index_bits_ff;
   logic [7:0]  hue_bands_ff;
   logic [7:0]  shades_ff;
   logic [15:0] grey_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff     <= INDEX_BITS_RESET;
         hue_bands_ff      <= HUE_BANDS_RESET;
         shades_ff         <= SHADES_RESET;
         grey_threshold_ff <= GREY_THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INDEX_BITS:     index_bits_ff     <= csr_wdata[4:0];
            CSR_HUE_BANDS:      hue_bands_ff      <= csr_wdata[7:0];
            CSR_SHADES:         shades_ff         <= csr_wdata[7:0];
            CSR_GREY_THRESHOLD: grey_threshold_ff <= csr_wdata[15:0];
         endcase
      end
   end

   // config-derived values; the user keeps them stable while items are in flight, the block does not enforce it
   logic [4:0]  bits_eff;
   logic [15:0] lim;
   logic [16:0] cp_wide;
   logic [15:0] cp;
   logic [17:0] gc_wide;
   logic [15:0] gc;

   assign bits_eff = (index_bits_ff > 5'd16) ? 5'd16 : index_bits_ff;
   assign lim      = 16'((17'd1 << bits_eff) - 17'd1);
   assign cp_wide  = 17'(hue_bands_ff) * (17'(shades_ff) + 17'd1);
   assign cp       = cp_wide[15:0];
   assign gc_wide  = 18'(lim) - 18'd1 - 18'(cp);
   assign gc       = gc_wide[17] ? 16'd0 : gc_wide[15:0];

   logic advance;
   logic rsp_valid_ff;
   rsp_type rsp_payload_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // stage 0: input register
   logic    s0_valid_ff;
   req_type s0_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_pix_ff <= req_payload;
      end
   end

   // max, min and hue numerator
   logic [7:0]  mx, mn, d;
   logic [10:0] hn, d6;
   hsv_flags_type s1_flags_in;

   always_comb begin
      logic [7:0] r, g, b;
      r  = s0_pix_ff.red;
      g  = s0_pix_ff.green;
      b  = s0_pix_ff.blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d  = mx - mn;
      d6 = 11'd6 * 11'(d);
      priority if (mx == r) begin
         hn = (g >= b) ? 11'(g) - 11'(b) : d6 - (11'(b) - 11'(g));
      end else if (mx == g) begin
         hn = 11'd2 * 11'(d) + 11'(b) - 11'(r);
      end else begin
         hn = 11'd4 * 11'(d) + 11'(r) - 11'(g);
      end
      s1_flags_in.bright  = (mx >= 8'd204);
      s1_flags_in.mx_zero = (mx == 8'd0);
      s1_flags_in.d_zero  = (d == 8'd0);
   end

   // stage 1: divider operands
   logic                     s1_valid_ff;
   logic [1:0][NW1-1:0]      s1_num_ff;
   logic [1:0][15:0]         s1_den_ff;
   hsv_flags_type            s1_flags_ff;
   logic [7:0]               s1_mx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_num_ff[0] <= NW1'(d) << F;
         s1_den_ff[0] <= 16'(mx);
         s1_num_ff[1] <= NW1'(hn) << F;
         s1_den_ff[1] <= 16'(d6);
         s1_flags_ff  <= s1_flags_in;
         s1_mx_ff     <= mx;
      end
   end

   logic                q1_valid;
   logic [1:0][NW1-1:0] q1;
   logic [SIDE1-1:0]    side1_out;
   hsv_flags_type       q1_flags;
   logic [7:0]          q1_mx;

   rhq_div #(
      .LANES  (2),
      .NUM_W  (NW1),
      .DEN_W  (16),
      .SIDE_W (SIDE1)
   ) u_hsv_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid_ff),
      .num       (s1_num_ff),
      .den       (s1_den_ff),
      .side      ({s1_flags_ff, s1_mx_ff}),
      .out_valid (q1_valid),
      .quo       (q1),
      .side_out  (side1_out)
   );

   assign q1_flags = side1_out[SIDE1-1 -: $bits(hsv_flags_type)];
   assign q1_mx    = side1_out[7:0];

   // grey decision and products
   logic [ONE_W-1:0] v_q, s_q, h_q, m_q, base;
   logic [SW-1:0]    s65, thr;
   shade_flags_type  s2_flags_in;
   logic [DW2-1:0]   e_val;

   always_comb begin
      logic [23:0] mx_rep;
      logic [31:0] thr_rep;
      // x/255 and x/65535 are repeating base-256 and base-65536 fractions
      mx_rep  = {q1_mx, q1_mx, q1_mx};
      thr_rep = {grey_threshold_ff, grey_threshold_ff};
      v_q   = (q1_mx == 8'hFF) ? ONE : {1'b0, mx_rep[23 -: F]};
      s_q   = q1_flags.mx_zero ? '0 : q1[0][F:0];
      h_q   = q1_flags.d_zero ? '0 : q1[1][F:0];
      m_q   = (grey_threshold_ff == 16'hFFFF) ? ONE : {1'b0, thr_rep[31 -: F]};
      s65   = (SW'(s_q) << 16) - SW'(s_q);
      thr   = SW'(grey_threshold_ff) << F;
      base  = q1_flags.bright ? (ONE - s_q) : (ONE - v_q);
      e_val = DW2'(ONE - m_q) << 1;
      s2_flags_in.grey   = (s65 < thr);
      s2_flags_in.bright = q1_flags.bright;
      s2_flags_in.e_zero = (e_val == '0);
   end

   // stage 2
   logic            s2_valid_ff;
   logic [TW-1:0]   s2_tnum_ff;
   logic [DW2-1:0]  s2_e_ff;
   logic [SW-1:0]   s2_vg_ff, s2_hc_ff;
   shade_flags_type s2_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= q1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_tnum_ff  <= TW'(base) * TW'(shades_ff);
         s2_e_ff     <= e_val;
         s2_vg_ff    <= SW'(v_q) * SW'(gc);
         s2_hc_ff    <= SW'(h_q) * SW'(cp);
         s2_flags_ff <= s2_flags_in;
      end
   end

   logic [0:0][NW2-1:0] num2;
   logic [0:0][DW2-1:0] den2;
   logic                q2_valid;
   logic [0:0][NW2-1:0] q2;
   logic [SIDE2-1:0]    side2_in, side2_out;

   assign num2[0]  = NW2'(s2_tnum_ff) << F;
   assign den2[0]  = s2_e_ff;
   assign side2_in = {s2_flags_ff, s2_vg_ff, s2_hc_ff};

   rhq_div #(
      .LANES  (1),
      .NUM_W  (NW2),
      .DEN_W  (DW2),
      .SIDE_W (SIDE2)
   ) u_shade_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_valid_ff),
      .num       (num2),
      .den       (den2),
      .side      (side2_in),
      .out_valid (q2_valid),
      .quo       (q2),
      .side_out  (side2_out)
   );

   // final index and saturation
   shade_flags_type f_flags;
   logic [SW-1:0]   f_vg, f_hc;
   logic [IW-1:0]   grey_idx, col_idx, half, idx;

   always_comb begin
      f_flags  = side2_out[SIDE2-1 -: 3];
      f_vg     = side2_out[2*SW-1 -: SW];
      f_hc     = side2_out[SW-1:0];
      half     = f_flags.bright ? '0 : (IW'(shades_ff >> 1) << F);
      col_idx  = (IW'(f_hc) + IW'(q2[0]) + half) >> F;
      grey_idx = IW'(cp) + ((IW'(f_vg) + (IW'(1) << (F - 1))) >> F);
      priority if (f_flags.grey) begin
         idx = grey_idx;
      end else if (f_flags.e_zero) begin
         idx = IW'(lim);
      end else begin
         idx = col_idx;
      end
      if (idx > IW'(lim)) idx = IW'(lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= q2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff.palette_index <= idx[15:0];
         rsp_payload_ff.is_grey       <= f_flags.grey;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule : rgb_to_hsv_palette_quantizer_top
`default_nettype wire

>>> verif/tb_rgb_to_hsv_palette_quantizer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rgb_to_hsv_palette_quantizer_top
// Self-checking bench: drives pixels through several palette settings and
// idling phases and compares every result with a built-in palette predictor.
// ---------------------------------------------------------------------------
module tb_rgb_to_hsv_palette_quantizer_top;
   import rhq_pkg::*;

   localparam int FB = FRACTION_BITS_DEFAULT;
   localparam int LATENCY = 3 * FB + 29;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_INDEX_BITS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // palette settings mirrored for the predictor
   logic [4:0]  cur_bits;
   logic [7:0]  cur_bands;
   logic [7:0]  cur_shades;
   logic [15:0] cur_thresh;

   rsp_type expected_palette_q[$];
   int fail_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   rgb_to_hsv_palette_quantizer_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic rsp_type predict_palette(req_type px);
      logic [63:0] one, r, g, b, mx, mn, d, s_q, v_q, cp, lim, idx, bits;
      logic [63:0] hn, h_q, m_q, den, term, gc;
      logic grey;
      rsp_type res;
      one = 64'd1 << FB;
      r = px.red; g = px.green; b = px.blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      bits = (cur_bits > 16) ? 64'd16 : 64'(cur_bits);
      lim = (64'd1 << bits) - 1;
      cp = 64'(cur_bands) * (64'(cur_shades) + 1);
      v_q = mx * one / 255;
      s_q = (mx != 0) ? d * one / mx : 64'd0;
      grey = (s_q * 65535 < 64'(cur_thresh) * one);
      if (grey) begin
         // overfull palette clamps the grey span to zero
         gc = (lim < cp + 1) ? 64'd0 : lim - 1 - cp;
         idx = cp + ((v_q * gc + (one >> 1)) >> FB);
      end else begin
         hn = 0; h_q = 0;
         if (d != 0) begin
            if (mx == r) hn = (g >= b) ? g - b : 6 * d - (b - g);
            else if (mx == g) hn = 2 * d + b - r;
            else hn = 4 * d + r - g;
            h_q = hn * one / (6 * d);
         end
         m_q = 64'(cur_thresh) * one / 65535;
         den = 2 * (one - m_q);
         if (den == 0) idx = lim;
         else begin
            if (mx * 5 >= 4 * 255) term = (one - s_q) * 64'(cur_shades) * one / den;
            else term = (one - v_q) * 64'(cur_shades) * one / den
                      + 64'(cur_shades >> 1) * one;
            idx = (h_q * cp + term) >> FB;
         end
      end
      if (idx > lim) idx = lim;
      res.palette_index = idx[15:0];
      res.is_grey = grey;
      return res;
   endfunction

   task automatic write_csr(csr_index_type idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_INDEX_BITS:     cur_bits = val[4:0];
         CSR_HUE_BANDS:      cur_bands = val[7:0];
         CSR_SHADES:         cur_shades = val[7:0];
         CSR_GREY_THRESHOLD: cur_thresh = val;
         default: ;
      endcase
   endtask

   task automatic set_palette(int bits, int bands, int shades, int thresh);
      write_csr(CSR_INDEX_BITS, 16'(bits));
      write_csr(CSR_HUE_BANDS, 16'(bands));
      write_csr(CSR_SHADES, 16'(shades));
      write_csr(CSR_GREY_THRESHOLD, 16'(thresh));
   endtask

   // called at a falling edge; returns at a falling edge after acceptance
   // with req_valid still high, so the next call replaces the pixel or wait_drained drops it
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{red: r, green: g, blue: b};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_palette_q.push_back(predict_palette('{red: r, green: g, blue: b}));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_palette_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_palette_q.size() == 0) begin
            $display("%0t: unexpected result index=%0d grey=%0b", $time,
                     rsp_payload.palette_index, rsp_payload.is_grey);
            fail_count++;
         end else begin
            rsp_type want;
            want = expected_palette_q.pop_front();
            if (want.palette_index !== rsp_payload.palette_index) begin
               $display("%0t: palette_index expected %0d actual %0d", $time,
                        want.palette_index, rsp_payload.palette_index);
               fail_count++;
            end
            if (want.is_grey !== rsp_payload.is_grey) begin
               $display("%0t: is_grey expected %0b actual %0b", $time,
                        want.is_grey, rsp_payload.is_grey);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** rgb_to_hsv_palette_quantizer_top: FAILED **");
         $finish;
      end
   end

   task automatic test_directed_pixels();
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd10);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd204, 8'd10, 8'd10);
      send_pixel(8'd203, 8'd10, 8'd10);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd100, 8'd90, 8'd95);
      send_pixel(8'd170, 8'd85, 8'd85);
      send_pixel(8'd10, 8'd200, 8'd40);
      wait_drained();
   endtask

   task automatic test_random_pixels(int count);
      repeat (count) begin
         case ($urandom_range(3))
            0: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            1: begin
               // near-grey pixels probe the threshold
               logic [7:0] base;
               base = 8'($urandom);
               send_pixel(base, base ^ 8'($urandom_range(7)), base ^ 8'($urandom_range(3)));
            end
            2: send_pixel(8'($urandom_range(255, 200)), 8'($urandom), 8'($urandom));
            default: send_pixel(8'($urandom_range(60)), 8'($urandom_range(60)),
                                8'($urandom_range(60)));
         endcase
      end
      wait_drained();
   endtask

   task automatic test_idle_phases();
      send_idle_pct = 0;  stall_pct = 0;  test_random_pixels(120);
      send_idle_pct = 81; stall_pct = 0;  test_random_pixels(80);
      send_idle_pct = 0;  stall_pct = 81; test_random_pixels(80);
      send_idle_pct = 30; stall_pct = 30; test_random_pixels(80);
      send_idle_pct = 0;  stall_pct = 0;
   endtask

   task automatic test_palette_settings();
      int cfg;
      // wide index, overfull palette, full and zero threshold, minimum sizes
      set_palette(31, 255, 254, 65535); test_directed_pixels(); test_random_pixels(60);
      set_palette(4, 255, 254, 0);      test_directed_pixels(); test_random_pixels(60);
      set_palette(16, 1, 2, 6554);      test_random_pixels(60);
      set_palette(5, 3, 2, 65534);      test_random_pixels(60);
      for (cfg = 0; cfg < 4; cfg++) begin
         set_palette($urandom_range(31), $urandom_range(255, 1), $urandom_range(254, 2),
                     $urandom_range(65535));
         send_idle_pct = 30; stall_pct = 30;
         test_random_pixels(50);
      end
      send_idle_pct = 0; stall_pct = 0;
   endtask

   initial begin
      cur_bits = INDEX_BITS_RESET;
      cur_bands = HUE_BANDS_RESET;
      cur_shades = SHADES_RESET;
      cur_thresh = GREY_THRESHOLD_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);
      test_directed_pixels();
      test_idle_phases();
      test_palette_settings();
      wait_drained();
      if (fail_count == 0) $display("** rgb_to_hsv_palette_quantizer_top: PASSED **");
      else $display("** rgb_to_hsv_palette_quantizer_top: FAILED **");
      $finish;
   end

endmodule
